[rtl/smsp_pkg.sv]
package smsp_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int WARM_STEPS = 8;
    localparam logic [14:0] MULT = 15'd16807;
    localparam logic [30:0] MODULUS = 31'h7FFF_FFFF;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] seed_value;
    } req_t;

    typedef struct packed {
        logic [30:0] number;
        logic [30:0] sequence_value;
    } rsp_t;

    typedef logic [3:0] step_t;

    localparam step_t S_IDLE = 4'd0;
    localparam step_t S_DISP = 4'd1;
    localparam step_t S_DMUL = 4'd2;
    localparam step_t S_DRD  = 4'd3;
    localparam step_t S_DWR  = 4'd4;
    localparam step_t S_WLD  = 4'd5;
    localparam step_t S_WMUL = 4'd6;
    localparam step_t S_WRED = 4'd7;
    localparam step_t S_FLD  = 4'd8;
    localparam step_t S_FMUL = 4'd9;
    localparam step_t S_FRED = 4'd10;
    localparam step_t S_FJMP = 4'd11;

    typedef enum logic [1:0] {
        C_NEXT   = 2'd0,
        C_ALWAYS = 2'd1,
        C_INIT   = 2'd2,
        C_CNT_NZ = 2'd3
    } cond_t;

    typedef struct packed {
        logic  idle;
        logic  mul;
        logic  slot_mul;
        logic  red;
        logic  fill;
        logic  warm_ld;
        logic  fill_ld;
        logic  rd;
        logic  commit;
        cond_t cond;
        step_t target;
    } uword_t;

    function automatic uword_t ucode(input step_t pc);
        uword_t w;
        w = '0;
        w.cond = C_NEXT;
        w.target = S_IDLE;
        case (pc)
            S_IDLE:
            begin
                w.idle = 1'b1;
            end
            S_DISP:
            begin
                w.cond = C_INIT;
                w.target = S_WLD;
            end
            S_DMUL:
            begin
                w.mul = 1'b1;
                w.slot_mul = 1'b1;
            end
            S_DRD:
            begin
                w.red = 1'b1;
                w.rd = 1'b1;
            end
            S_DWR:
            begin
                w.commit = 1'b1;
                w.cond = C_ALWAYS;
                w.target = S_IDLE;
            end
            S_WLD:
            begin
                w.warm_ld = 1'b1;
            end
            S_WMUL:
            begin
                w.mul = 1'b1;
            end
            S_WRED:
            begin
                w.red = 1'b1;
                w.cond = C_CNT_NZ;
                w.target = S_WMUL;
            end
            S_FLD:
            begin
                w.fill_ld = 1'b1;
            end
            S_FMUL:
            begin
                w.mul = 1'b1;
            end
            S_FRED:
            begin
                w.red = 1'b1;
                w.fill = 1'b1;
                w.cond = C_CNT_NZ;
                w.target = S_FMUL;
            end
            S_FJMP:
            begin
                w.cond = C_ALWAYS;
                w.target = S_DMUL;
            end
            default:
            begin
                w.cond = C_ALWAYS;
                w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

[rtl/smsp_lcg.sv]
module smsp_lcg (
    input  logic        clk,
    input  logic        mul_en,
    input  logic [31:0] x,
    output logic [30:0] result
);

    logic [46:0] prod_reg;
    logic [31:0] sum;

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= 47'(x) * 47'(smsp_pkg::MULT);
        end
    end

    // mersenne fold: hi + lo, one conditional subtract
    assign sum = 32'(prod_reg[30:0]) + 32'(prod_reg[46:31]);
    assign result = (sum >= {1'b0, smsp_pkg::MODULUS})
                    ? 31'(sum - {1'b0, smsp_pkg::MODULUS}) : sum[30:0];

endmodule

[rtl/shuffled_minimal_standard_prng.sv]
// Shuffled minimal standard generator: 16807 * x mod (2^31 - 1), followed by
// a Bays-Durham shuffle table of TABLE_DEPTH entries.
// Request channel (req_valid / req_stall / req): kind 0 draws the next number,
// kind 1 loads seed_value first. A non-positive seed, an empty table or a zero
// generator value starts initialization: 8 warm-up steps, then the table is
// filled from the top entry down.
// Response channel (rsp_valid / rsp_stall / rsp): one response per request,
// with the shuffled number and the new generator value.
// A microcoded sequencer runs every request; each generator step passes through
// the shared multiply / modulo unit: a multiply, then a fold.
// A plain draw steps through dispatch, multiply, table read and commit; the
// next request is taken only after the commit, back in the idle step.
// Initialization runs the warm-up and the table fill between dispatch and multiply.
// req_stall is high from acceptance until the response is written to the
// output register. A stalled response holds; the sequencer waits at its final
// step only if a previous response is still held there.
// Reset: generator value 1, table marked empty, so the first request always
// initializes. The table memory itself is not cleared.
module shuffled_minimal_standard_prng #(
    parameter int TABLE_DEPTH = smsp_pkg::TABLE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  smsp_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output smsp_pkg::rsp_t  rsp
);

    localparam int IDXW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = (IDXW > 3) ? IDXW : 3;
    localparam longint unsigned SLOT_DIV = 64'd1 + 64'd2147483646 / 64'(TABLE_DEPTH);
    localparam int SH = 31 + $clog2(SLOT_DIV);
    localparam logic [63:0] RECIP64 = ((64'd1 << SH) + SLOT_DIV - 64'd1) / SLOT_DIV;
    localparam logic [31:0] RECIP = RECIP64[31:0];

    smsp_pkg::step_t  pc_reg, pc_next;
    smsp_pkg::uword_t uw;

    logic [31:0]     x_reg;
    logic [30:0]     gen_reg;
    logic [30:0]     last_reg;
    logic            init_reg;
    logic [CW-1:0]   cnt_reg;
    logic [62:0]     sprod_reg;
    logic [IDXW-1:0] slot_reg;
    logic [30:0]     rd_reg;
    logic            rsp_valid_reg;
    smsp_pkg::rsp_t  rsp_reg;

    logic [30:0] mem [TABLE_DEPTH];

    logic            accept;
    logic            hold;
    logic            jump;
    logic            cnt_nz;
    logic [30:0]     red_val;
    logic [63:0]     quot;
    logic [IDXW-1:0] slot;
    logic            seed_neg;
    logic            seed_zero;
    logic [31:0]     x_start;
    logic [31:0]     x_init;
    logic            need_init;
    logic            mem_we;
    logic [IDXW-1:0] mem_waddr;
    logic [30:0]     mem_wdata;

    smsp_lcg u_lcg (
        .clk    (clk),
        .mul_en (uw.mul),
        .x      (x_reg),
        .result (red_val)
    );

    assign uw = smsp_pkg::ucode(pc_reg);

    assign accept = uw.idle && req_valid;
    assign req_stall = !uw.idle;
    assign cnt_nz = (cnt_reg != '0);
    assign hold = (uw.idle && !req_valid) || (uw.commit && rsp_valid_reg && rsp_stall);

    always_comb
    begin
        case (uw.cond)
            smsp_pkg::C_NEXT:   jump = 1'b0;
            smsp_pkg::C_ALWAYS: jump = 1'b1;
            smsp_pkg::C_INIT:   jump = init_reg;
            smsp_pkg::C_CNT_NZ: jump = cnt_nz;
            default:            jump = 1'b0;
        endcase
    end

    assign pc_next = hold ? pc_reg : (jump ? uw.target : smsp_pkg::step_t'(pc_reg + 4'd1));

    // starting point of a request
    assign seed_neg = req.seed_value[31];
    assign seed_zero = (req.seed_value == '0);
    assign x_start = (req.kind && !seed_neg && !seed_zero)
                     ? 32'(req.seed_value) : {1'b0, gen_reg};
    assign need_init = (req.kind && (seed_neg || seed_zero)) || (last_reg == '0)
                       || (x_start == '0);
    assign x_init = (req.kind && seed_neg) ? (~32'(req.seed_value) + 32'd1) : 32'd1;

    // table slot from the previous output
    assign quot = 64'(sprod_reg) >> SH;
    assign slot = (quot >= 64'(TABLE_DEPTH)) ? IDXW'(TABLE_DEPTH - 1) : quot[IDXW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= smsp_pkg::S_IDLE;
            gen_reg <= 31'd1;
            last_reg <= '0;
            init_reg <= 1'b0;
            cnt_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg <= pc_next;
            if (accept)
            begin
                init_reg <= need_init;
            end
            if (uw.warm_ld)
            begin
                cnt_reg <= CW'(smsp_pkg::WARM_STEPS - 1);
            end
            else if (uw.fill_ld)
            begin
                cnt_reg <= CW'(TABLE_DEPTH - 1);
            end
            else if (uw.cond == smsp_pkg::C_CNT_NZ && cnt_nz)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
            if (uw.fill)
            begin
                last_reg <= red_val;
            end
            if (uw.commit && !hold)
            begin
                gen_reg <= x_reg[30:0];
                last_reg <= rd_reg;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg <= need_init ? x_init : x_start;
        end
        else if (uw.red)
        begin
            x_reg <= {1'b0, red_val};
        end
        if (uw.slot_mul)
        begin
            sprod_reg <= 63'(last_reg) * 63'(RECIP);
        end
        if (uw.commit && !hold)
        begin
            rsp_reg.number <= rd_reg;
            rsp_reg.sequence_value <= x_reg[30:0];
        end
    end

    // shuffle table
    assign mem_we = uw.fill || (uw.commit && !hold);
    assign mem_waddr = uw.fill ? cnt_reg[IDXW-1:0] : slot_reg;
    assign mem_wdata = uw.fill ? red_val : x_reg[30:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (uw.rd)
        begin
            rd_reg <= mem[slot];
            slot_reg <= slot;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

endmodule

[rtl/smsp_checker.sv]
module smsp_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input smsp_pkg::rsp_t rsp
);

    logic req_acc;

    assign req_acc = req_valid && !req_stall;

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // busy right after a request is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |=> req_stall)
        else $error("request channel open while working");

    // a new response only comes out of a running request
    a_rsp_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("response without a running request");

    // no response in the cycle right after acceptance
    a_min_lat: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |=> !$rose(rsp_valid))
        else $error("response too early");

endmodule

bind shuffled_minimal_standard_prng smsp_checker u_smsp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

[tb/shuffled_minimal_standard_prng_tb.sv]
`timescale 1ns / 100ps

module shuffled_minimal_standard_prng_tb;

    localparam int PLAN_ROWS = 21;
    localparam int RANDOM_DRAWS = 1030;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 20;
    localparam int SLOT_W = $clog2(smsp_pkg::TABLE_DEPTH);
    localparam logic [30:0] SLOT_DIV =
        31'(31'd1 + (smsp_pkg::MODULUS - 31'd1) / smsp_pkg::TABLE_DEPTH);

    typedef struct packed {
        logic        kind;
        logic [31:0] seed;
        logic        typed;
        logic [30:0] number;
        logic [30:0] sequence_value;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    smsp_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    smsp_pkg::rsp_t rsp;

    smsp_pkg::rsp_t expected_draws [$];
    int mismatches = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    bit calm = 1'b0;

    logic [30:0] gen_state;
    logic [30:0] last_pick;
    logic [30:0] shuffle_mem [smsp_pkg::TABLE_DEPTH];

    // kind, seed, typed, number, sequence_value
    plan_row_t plan [PLAN_ROWS] = '{
        '{1'b0, 32'h0000_0000, 1'b0, 31'd0, 31'd0},
        '{1'b0, 32'hFFFF_FFFF, 1'b0, 31'd0, 31'd0},
        '{1'b1, 32'd12345,     1'b0, 31'd0, 31'd0},
        '{1'b1, 32'h0000_0001, 1'b0, 31'd0, 31'd0},
        '{1'b1, 32'h0000_0000, 1'b0, 31'd0, 31'd0},
        '{1'b1, 32'hFFFF_FFFF, 1'b0, 31'd0, 31'd0},
        '{1'b0, 32'h7FFF_FFFF, 1'b0, 31'd0, 31'd0},
        '{1'b1, 32'h8000_0000, 1'b0, 31'd0, 31'd0},
        '{1'b0, 32'h8000_0000, 1'b0, 31'd0, 31'd0},
        '{1'b1, 32'h8000_0001, 1'b1, 31'd0, 31'd0},
        '{1'b0, 32'h0000_0000, 1'b0, 31'd0, 31'd0},
        '{1'b1, 32'h7FFF_FFFF, 1'b0, 31'd0, 31'd0},
        '{1'b0, 32'h0000_0000, 1'b0, 31'd0, 31'd0},
        '{1'b1, 32'hFFFF_FFFB, 1'b0, 31'd0, 31'd0},
        '{1'b0, 32'h5555_5555, 1'b0, 31'd0, 31'd0},
        '{1'b0, 32'hAAAA_AAAA, 1'b0, 31'd0, 31'd0},
        '{1'b1, 32'h5555_5555, 1'b0, 31'd0, 31'd0},
        '{1'b1, 32'hAAAA_AAAA, 1'b0, 31'd0, 31'd0},
        '{1'b1, 32'h7FFF_FFFE, 1'b0, 31'd0, 31'd0},
        '{1'b0, 32'h0000_0000, 1'b0, 31'd0, 31'd0},
        '{1'b0, 32'h0000_0000, 1'b0, 31'd0, 31'd0}
    };

    shuffled_minimal_standard_prng dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #10 clk = ~clk;

    function automatic logic [63:0] mcg_step(input logic [63:0] x);
        return (x * 64'(smsp_pkg::MULT)) % 64'(smsp_pkg::MODULUS);
    endfunction

    function automatic smsp_pkg::rsp_t predict_draw(input smsp_pkg::req_t r);
        logic [63:0] x;
        logic [31:0] raw;
        logic [31:0] mag;
        logic seed_neg;
        logic seed_zero;
        logic [30:0] quo;
        logic [SLOT_W-1:0] slot;
        smsp_pkg::rsp_t res;
        raw = r.seed_value;
        seed_neg = raw[31];
        seed_zero = (raw == 32'd0);
        x = 64'(gen_state);
        if (r.kind && !seed_neg && !seed_zero)
            x = 64'(raw);
        if ((r.kind && (seed_neg || seed_zero)) || last_pick == 31'd0 || x == 64'd0)
        begin
            if (r.kind && seed_neg)
            begin
                mag = (~raw) + 32'd1;
                x = {32'd0, mag};
            end
            else
                x = 64'd1;
            repeat (smsp_pkg::WARM_STEPS) x = mcg_step(x);
            for (int t = smsp_pkg::TABLE_DEPTH - 1; t >= 0; t--)
            begin
                x = mcg_step(x);
                shuffle_mem[t] = x[30:0];
            end
            last_pick = shuffle_mem[0];
        end
        x = mcg_step(x);
        quo = last_pick / SLOT_DIV;
        if (quo >= 31'(smsp_pkg::TABLE_DEPTH))
            slot = SLOT_W'(smsp_pkg::TABLE_DEPTH - 1);
        else
            slot = quo[SLOT_W-1:0];
        res.number = shuffle_mem[slot];
        shuffle_mem[slot] = x[30:0];
        gen_state = x[30:0];
        last_pick = res.number;
        res.sequence_value = gen_state;
        return res;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(input smsp_pkg::req_t r, input bit typed,
                                input smsp_pkg::rsp_t typed_rsp);
        int gap;
        smsp_pkg::rsp_t predicted;
        gap = calm ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        predicted = predict_draw(r);
        expected_draws.push_back(typed ? typed_rsp : predicted);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (expected_draws.size() != 0) @(negedge clk);
        @(negedge clk);
    endtask

    function automatic logic [31:0] random_seed();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'($urandom_range(1, 1000));
            2: return -32'($urandom_range(1, 1000));
            3: return 32'd0;
            4:
            begin
                case ($urandom_range(0, 4))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h8000_0001;
                    3: return 32'h0000_0001;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return {1'b0, 31'($urandom)};
        endcase
    endfunction

    // response side
    always @(posedge clk)
    begin
        smsp_pkg::rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            stall_left = calm ? 0 : $urandom_range(0, 9);
            if (expected_draws.size() == 0)
            begin
                $display("%0t: unexpected response number %h sequence_value %h",
                         $time, rsp.number, rsp.sequence_value);
                mismatches++;
            end
            else
            begin
                want = expected_draws.pop_front();
                if (rsp.number !== want.number)
                begin
                    $display("%0t: number expected %h actual %h",
                             $time, want.number, rsp.number);
                    mismatches++;
                end
                if (rsp.sequence_value !== want.sequence_value)
                begin
                    $display("%0t: sequence_value expected %h actual %h",
                             $time, want.sequence_value, rsp.sequence_value);
                    mismatches++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            rsp_stall <= 1'b1;
            stall_left--;
        end
        else
            rsp_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        smsp_pkg::req_t r;
        smsp_pkg::rsp_t typed_rsp;
        gen_state = 31'd1;
        last_pick = 31'd0;
        foreach (shuffle_mem[t])
            shuffle_mem[t] = 31'd0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < PLAN_ROWS; i++)
        begin
            if (i % 7 == 0)
                calm = ~calm;
            r.kind = plan[i].kind;
            r.seed_value = plan[i].seed;
            typed_rsp.number = plan[i].number;
            typed_rsp.sequence_value = plan[i].sequence_value;
            send_request(r, plan[i].typed, typed_rsp);
        end
        wait_drained();

        typed_rsp = '0;
        for (int i = 0; i < RANDOM_DRAWS; i++)
        begin
            if (i % 100 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (i == RANDOM_DRAWS / 2)
                wait_drained();
            r.kind = ($urandom_range(0, 5) == 0);
            r.seed_value = r.kind ? random_seed() : 32'($urandom);
            send_request(r, 1'b0, typed_rsp);
        end

        req_valid <= 1'b0;
        while (expected_draws.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[filelist.f]
rtl/smsp_pkg.sv
rtl/smsp_lcg.sv
rtl/shuffled_minimal_standard_prng.sv
rtl/smsp_checker.sv
tb/shuffled_minimal_standard_prng_tb.sv
